// ----- design/c2d_pkg.sv -----
package c2d_pkg;

  localparam int unsigned DefMaxWidth    = 64;
  localparam int unsigned DefMaxChannels = 16;
  localparam int unsigned DefMaxFilters  = 16;
  localparam int unsigned ResultLimit    = 16;
  localparam int unsigned MaxHeight      = 4096;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_BIAS   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2,
    REG_FILTERS  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MAC,
    ST_DRAIN,
    ST_SETTLE,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic mac_en;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fire;
    logic last_tap;
    logic last_filter;
  } stat_t;

endpackage

// ----- design/conv2d_3x3_valid_multichannel.sv -----
// A firing sample runs each filter through clear, accumulate over the 3x3 taps of
// every channel, drain, settle, finish and output; the next filter follows once the
// result is taken. Loads and non-firing samples are taken one item per cycle
// while idle; a firing sample holds the input until the last result is taken.
// Reset presets counters, state and config; stores are unset until written.
module conv2d_3x3_valid_multichannel #(
  parameter int unsigned MAX_WIDTH    = c2d_pkg::DefMaxWidth,
  parameter int unsigned MAX_CHANNELS = c2d_pkg::DefMaxChannels,
  parameter int unsigned MAX_FILTERS  = c2d_pkg::DefMaxFilters
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [c2d_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [c2d_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [11:0]                  coef_index_i,
  input  logic signed [15:0]           coef_value_i,
  input  logic signed [15:0]           sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           value_o,
  output logic [3:0]                   filter_index_o,
  output logic [11:0]                  out_row_o,
  output logic [5:0]                   out_col_o,
  output logic                         last_o
);
  import c2d_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  c2d_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  c2d_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS), .MAX_FILTERS(MAX_FILTERS)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_acc_i(in_valid_i && in_ready_o),
    .op_i, .coef_index_i, .coef_value_i, .sample_i,
    .cmd_i(cmd), .stat_o(stat),
    .value_o, .filter_index_o, .out_row_o, .out_col_o, .last_o
  );

endmodule

// ----- design/c2d_ctrl.sv -----
module c2d_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  c2d_pkg::stat_t stat_i,
  output c2d_pkg::cmd_t  cmd_o
);
  import c2d_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && stat_i.fire) begin
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (stat_i.last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.step = 1'b1;
          state_d    = stat_i.last_filter ? ST_IDLE : ST_CLEAR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_out_only_in_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("result shown while taking input");
  a_finish_then_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o) else $error("finish not followed by result");
  a_clear_then_mac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> cmd_o.mac_en) else $error("clear not followed by accumulate");

endmodule

// ----- design/c2d_datapath.sv -----
module c2d_datapath #(
  parameter int unsigned MAX_WIDTH    = c2d_pkg::DefMaxWidth,
  parameter int unsigned MAX_CHANNELS = c2d_pkg::DefMaxChannels,
  parameter int unsigned MAX_FILTERS  = c2d_pkg::DefMaxFilters
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [c2d_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [c2d_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_acc_i,
  input  logic [1:0]                    op_i,
  input  logic [11:0]                   coef_index_i,
  input  logic signed [15:0]            coef_value_i,
  input  logic signed [15:0]            sample_i,
  input  c2d_pkg::cmd_t                 cmd_i,
  output c2d_pkg::stat_t                stat_o,
  output logic signed [15:0]            value_o,
  output logic [3:0]                    filter_index_o,
  output logic [11:0]                   out_row_o,
  output logic [5:0]                    out_col_o,
  output logic                          last_o
);
  import c2d_pkg::*;

  localparam int unsigned WDepth = 9 * MAX_CHANNELS * MAX_FILTERS;
  localparam int unsigned LDepth = 3 * MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned WAw    = $clog2(WDepth);
  localparam int unsigned LAw    = $clog2(LDepth);
  localparam int unsigned ChW    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned ColW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned FW     = $clog2(MAX_FILTERS + 1);
  localparam int unsigned FIw    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int unsigned FcMax  = (MAX_FILTERS < ResultLimit) ? MAX_FILTERS : ResultLimit;

  logic [6:0]  width_q;
  logic [12:0] height_q;
  logic [4:0]  chans_q, filts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd64;
      height_q <= 13'd64;
      chans_q  <= 5'd1;
      filts_q  <= 5'd16;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_WIDTH:    width_q  <= cfg_data_i[6:0];
        REG_HEIGHT:   height_q <= cfg_data_i;
        REG_CHANNELS: chans_q  <= cfg_data_i[4:0];
        REG_FILTERS:  filts_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [ColW-1:0] w_eff;
  logic [12:0]     h_eff;
  logic [ChW-1:0]  cc_eff;
  logic [FW-1:0]   fc_eff;

  always_comb begin
    if (width_q < 7'd3) w_eff = ColW'(3);
    else if (32'(width_q) > MAX_WIDTH) w_eff = ColW'(MAX_WIDTH);
    else w_eff = ColW'(width_q);
    if (height_q < 13'd3) h_eff = 13'd3;
    else if (32'(height_q) > MaxHeight) h_eff = 13'(MaxHeight);
    else h_eff = height_q;
    if (chans_q == 5'd0) cc_eff = ChW'(1);
    else if (32'(chans_q) > MAX_CHANNELS) cc_eff = ChW'(MAX_CHANNELS);
    else cc_eff = ChW'(chans_q);
    if (filts_q == 5'd0) fc_eff = FW'(1);
    else if (32'(filts_q) > FcMax) fc_eff = FW'(FcMax);
    else fc_eff = FW'(filts_q);
  end

  logic [11:0]     row_q;
  logic [1:0]      slot_q;
  logic [ColW-1:0] col_q;
  logic [ChW-1:0]  ch_q;

  logic is_smp, fire;
  assign is_smp = in_acc_i && (op_e'(op_i) == OP_SAMPLE);
  assign fire = (32'(ch_q) == 32'(cc_eff) - 1) && (row_q >= 12'd2) && (col_q >= ColW'(2))
                && ({1'b0, row_q} < h_eff) && (col_q < w_eff);

  logic [11:0]     prow_q;
  logic [ColW-1:0] pcol_q;
  logic [1:0]      pslot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      slot_q <= '0;
      col_q  <= '0;
      ch_q   <= '0;
    end else if (is_smp) begin
      if (32'(ch_q) + 1 >= 32'(cc_eff)) begin
        ch_q <= '0;
        if (32'(col_q) + 1 >= 32'(w_eff)) begin
          col_q <= '0;
          if ({1'b0, row_q} + 13'd1 >= h_eff) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + 12'd1;
            slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
          end
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end else begin
        ch_q <= ch_q + ChW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_smp && fire) begin
      prow_q  <= row_q;
      pcol_q  <= col_q;
      pslot_q <= slot_q;
    end
  end

  logic signed [15:0] wmem [WDepth];
  logic signed [15:0] lmem [LDepth];
  logic signed [15:0] bmem [MAX_FILTERS];

  always_ff @(posedge clk_i) begin
    if (in_acc_i && op_e'(op_i) == OP_WEIGHT && 32'(coef_index_i) < WDepth) begin
      wmem[WAw'(coef_index_i)] <= coef_value_i;
    end
    if (in_acc_i && op_e'(op_i) == OP_BIAS && 32'(coef_index_i) < MAX_FILTERS) begin
      bmem[coef_index_i[FIw-1:0]] <= coef_value_i;
    end
    if (is_smp && 32'(col_q) < MAX_WIDTH && 32'(ch_q) < MAX_CHANNELS) begin
      lmem[LAw'((32'(slot_q) * MAX_WIDTH + 32'(col_q)) * MAX_CHANNELS + 32'(ch_q))]
        <= sample_i;
    end
  end

  logic [1:0]     ky_q, kx_q;
  logic [ChW-1:0] c_q;
  logic [FW-1:0]  f_q;
  logic [2:0]     rsum;
  logic [1:0]     rslot;
  logic [ColW-1:0] rcol;

  always_comb begin
    rsum  = {1'b0, pslot_q} + 3'd1 + {1'b0, ky_q};
    rslot = (rsum >= 3'd3) ? 2'(rsum - 3'd3) : rsum[1:0];
    rcol  = pcol_q - ColW'(2) + ColW'(kx_q);
  end

  logic last_tap;
  assign last_tap = (ky_q == 2'd2) && (kx_q == 2'd2) && (32'(c_q) + 1 == 32'(cc_eff));

  logic signed [15:0] s_q, w_q;
  logic               v1_q, v2_q;
  logic signed [31:0] p_q;
  logic signed [47:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      s_q <= lmem[LAw'((32'(rslot) * MAX_WIDTH + 32'(rcol)) * MAX_CHANNELS + 32'(c_q))];
      w_q <= wmem[WAw'(((32'(ky_q) * 3 + 32'(kx_q)) * MAX_CHANNELS + 32'(c_q))
                       * MAX_FILTERS + 32'(f_q))];
    end
    p_q <= s_q * w_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ky_q <= '0; kx_q <= '0; c_q <= '0; f_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_en;
      v2_q <= v1_q;
      if (is_smp && fire) f_q <= '0;
      else if (cmd_i.step) f_q <= f_q + FW'(1);
      if (cmd_i.clear) begin
        ky_q <= '0; kx_q <= '0; c_q <= '0;
      end else if (cmd_i.mac_en) begin
        if (32'(c_q) + 1 == 32'(cc_eff)) begin
          c_q <= '0;
          if (kx_q == 2'd2) begin
            kx_q <= '0;
            ky_q <= ky_q + 2'd1;
          end else begin
            kx_q <= kx_q + 2'd1;
          end
        end else begin
          c_q <= c_q + ChW'(1);
        end
      end
    end
  end

  logic signed [47:0] sum;
  logic signed [35:0] q;
  assign sum = acc_q + {{20{bmem[f_q[FIw-1:0]][15]}}, bmem[f_q[FIw-1:0]], 12'd0};
  assign q   = sum[47:12];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) acc_q <= '0;
    else if (v2_q) acc_q <= acc_q + 48'(p_q);
    if (cmd_i.finish) begin
      if (q > 36'sd32767) value_o <= 16'sh7fff;
      else if (q < -36'sd32768) value_o <= 16'sh8000;
      else value_o <= q[15:0];
      filter_index_o <= 4'(f_q);
      out_row_o      <= prow_q - 12'd2;
      out_col_o      <= 6'(pcol_q - ColW'(2));
      last_o         <= (32'(f_q) + 1 == 32'(fc_eff));
    end
  end

  assign stat_o.fire        = fire && (op_e'(op_i) == OP_SAMPLE);
  assign stat_o.last_tap    = last_tap;
  assign stat_o.last_filter = (32'(f_q) + 1 >= 32'(fc_eff));

  a_fire_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_smp && fire) |-> (col_q >= ColW'(2))) else $error("window fired early");
  a_clear_resets_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (acc_q == 48'sd0)) else $error("accumulator not cleared");
  a_filter_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (32'(f_q) < 32'(fc_eff))) else $error("filter index overrun");

endmodule
